FILE: src/rtn_pkg.sv
// Package: shared types, numeral tables and letter codes for the Roman numeral unit.
package rtn_pkg;

	localparam int ValueWidth = 12;
	localparam int CharWidth  = 8;
	localparam int NumSyms    = 13;
	localparam int SymIdxBits = $clog2(NumSyms);

	// Front queue between acceptance and conversion.
	localparam int QueueDepth   = 2;
	localparam int QueuePtrBits = $clog2(QueueDepth);

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [CharWidth-1:0]  char_t;
	typedef logic [SymIdxBits-1:0] sym_idx_t;
	typedef logic [QueuePtrBits-1:0] qptr_t;
	typedef logic [QueuePtrBits:0]   qcnt_t;

	localparam char_t ChI = "I";
	localparam char_t ChV = "V";
	localparam char_t ChX = "X";
	localparam char_t ChL = "L";
	localparam char_t ChC = "C";
	localparam char_t ChD = "D";
	localparam char_t ChM = "M";

	// Greedy table, largest value first.
	localparam value_t SymValue [NumSyms] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};

	localparam char_t SymFirst [NumSyms] = '{
		ChM, ChC, ChD, ChC, ChC, ChX, ChL, ChX, ChX, ChI, ChV, ChI, ChI
	};

	localparam char_t SymSecond [NumSyms] = '{
		ChM, ChM, ChD, ChD, ChC, ChC, ChL, ChL, ChX, ChX, ChV, ChV, ChI
	};

	// Set where the value is written with two letters (subtractive pairs).
	localparam logic SymPair [NumSyms] = '{
		1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
	};

endpackage

FILE: src/rtn_in_if.sv
// Interface: valid/ready channel carrying one integer to convert.
interface rtn_in_if;
	logic           valid;
	logic           ready;
	rtn_pkg::value_t value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

FILE: src/rtn_out_if.sv
// Interface: valid/ready channel carrying one numeral letter and its end flag.
interface rtn_out_if;
	logic           valid;
	logic           ready;
	rtn_pkg::char_t char_code;
	logic           last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

FILE: src/rtn_front.sv
// Front end: accept integers, drop zeros, hold the rest in a two-entry queue.
module rtn_front (
	input  logic clk,
	input  logic arst_n,
	rtn_in_if.sink   number,
	rtn_in_if.source job
);
	import rtn_pkg::*;

	value_t           mem_q [QueueDepth];
	qptr_t            wr_ptr_q;
	qptr_t            rd_ptr_q;
	qcnt_t            cnt_q;
	logic             push;
	logic             pop;

	assign number.ready = (cnt_q != qcnt_t'(QueueDepth));
	// Zero has an empty numeral: take the beat and drop it.
	assign push = number.valid && number.ready && (number.value != '0);
	assign pop  = job.valid && job.ready;

	assign job.valid = (cnt_q != '0);
	assign job.value = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= number.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == qptr_t'(QueueDepth - 1)) ? '0 : wr_ptr_q + qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == qptr_t'(QueueDepth - 1)) ? '0 : rd_ptr_q + qptr_t'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + qcnt_t'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - qcnt_t'(1);
			end
		end
	end

endmodule

FILE: src/rtn_back.sv
// Back end: greedy conversion engine emitting one letter per cycle while the numeral channel is not stalled.
module rtn_back (
	input  logic clk,
	input  logic arst_n,
	rtn_in_if.sink    job,
	rtn_out_if.source numeral
);
	import rtn_pkg::*;

	logic     busy_q;
	logic     pend_q;
	char_t    pend_char_q;
	value_t   rest_q;
	logic     ovalid_q;
	char_t    char_q;
	logic     last_q;

	sym_idx_t k;
	value_t   new_rest;
	char_t    emit_char;
	logic     emit_last;
	logic     adv;
	logic     pop;

	// Pick the largest table value that fits in the remainder.
	always_comb begin
		k = sym_idx_t'(NumSyms - 1);
		for (int i = NumSyms - 1; i >= 0; i--) begin
			if (SymValue[i] <= rest_q) begin
				k = sym_idx_t'(i);
			end
		end
	end

	assign new_rest = rest_q - SymValue[k];

	always_comb begin
		if (pend_q) begin
			emit_char = pend_char_q;
			emit_last = (rest_q == '0);
		end else begin
			emit_char = SymFirst[k];
			emit_last = !SymPair[k] && (new_rest == '0);
		end
	end

	assign adv = busy_q && (!ovalid_q || numeral.ready);
	// Load the next job when idle or on the final letter of the current one.
	assign job.ready = !busy_q || (adv && emit_last);
	assign pop       = job.valid && job.ready;

	assign numeral.valid     = ovalid_q;
	assign numeral.char_code = char_q;
	assign numeral.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (adv && emit_last) begin
				busy_q <= 1'b0;
			end
			if (pop) begin
				pend_q <= 1'b0;
			end else if (adv) begin
				pend_q <= !pend_q && SymPair[k];
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (numeral.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rest_q <= job.value;
		end else if (adv && !pend_q) begin
			rest_q <= new_rest;
		end
		if (adv && !pend_q) begin
			pend_char_q <= SymSecond[k];
		end
		if (adv) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

endmodule

FILE: src/integer_to_roman_numeral_unit.sv
// Top level: integer to Roman numeral converter, front queue plus greedy back end.
//
//   channel   dir   payload               beat
//   number    in    value[11:0]           one integer, 0..4095
//   numeral   out   char_code[7:0], last  one ASCII letter, last on final letter
//
// Each nonzero value yields one letter per cycle while numeral.ready is high,
// 1 to 15 letters; the back end's single greedy step (compare against all
// thirteen table values, subtract one) sets that rate.
// A value of zero is taken and dropped, giving no letters.
// arst_n clears queue and engine state; letters are held while numeral.ready
// is low, and number keeps being taken until the two-entry queue fills.
module integer_to_roman_numeral_unit (
	input  logic clk,
	input  logic arst_n,
	rtn_in_if.sink    number,
	rtn_out_if.source numeral
);
	import rtn_pkg::*;

	// Queue-to-engine channel: nonzero values waiting for conversion.
	rtn_in_if job ();

	// Front: accept beats, filter zeros, buffer.
	rtn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number),
		.job    (job)
	);

	// Back: walk the greedy table, emit letters through the output register.
	rtn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (job),
		.numeral (numeral)
	);

endmodule

FILE: dv/testbench.sv
// Testbench for the integer to Roman numeral unit: directed table, random values, letter checks.
`timescale 1ns / 1ps

module testbench;
	import rtn_pkg::*;

	// One expected letter of a numeral, with its end flag.
	typedef struct packed {
		char_t code;
		logic  last;
	} letter_t;

	typedef char_t letter_q_t [$];

	// Greedy table for the predictor: weight and its one- or two-letter spelling.
	// A zero upper byte means a single letter.
	localparam int NumeralWeight [13] = '{
		1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
	};
	localparam logic [15:0] NumeralText [13] = '{
		"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX", "V", "IV", "I"
	};

	// Text that tells the sender to take the numeral from the predictor.
	localparam string Predicted = "*";
	localparam int    DirectedRows = 24;
	localparam int    SqueezeCycles = 300;
	localparam int    DrainCycles = 20;
	localparam int    ReportLimit = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtn_in_if  number_ch ();
	rtn_out_if numeral_ch ();

	integer_to_roman_numeral_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.number  (number_ch),
		.numeral (numeral_ch)
	);

	// Letters owed by the block, oldest first.
	letter_t letters_due [$];
	int      fault_count = 0;

	// Idling knobs, in percent; the hold flag freezes the receiver outright.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	bit squeeze_go = 1'b0;

	// Directed table: extremes, every subtractive pair, zero, the longest
	// numeral, values with a fourth M, and alternating bit patterns. Rows
	// whose numeral reads off at a glance carry it; the rest use the predictor.
	value_t row_value [DirectedRows] = '{
		12'd0, 12'd1, 12'd4, 12'd8, 12'd9, 12'd14, 12'd40, 12'd49,
		12'd90, 12'd99, 12'd400, 12'd444, 12'd900, 12'd1000, 12'd1994, 12'd1365,
		12'd2730, 12'd2048, 12'd3888, 12'd3999, 12'd4000, 12'd4001, 12'd4094, 12'd4095
	};
	string row_text [DirectedRows] = '{
		"", "I", "IV", "VIII", "IX", Predicted, "XL", Predicted,
		"XC", Predicted, "CD", Predicted, "CM", "M", Predicted, Predicted,
		Predicted, Predicted, "MMMDCCCLXXXVIII", "MMMCMXCIX", "MMMM", Predicted,
		Predicted, "MMMMXCV"
	};

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard limit on the run, far beyond the slowest correct one.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Greedy conversion: take the largest weight that fits, append its letters.
	function automatic letter_q_t roman_letters(value_t v);
		letter_q_t q;
		int        rest;
		rest = int'(v);
		for (int k = 0; k < 13; k++) begin
			while (rest >= NumeralWeight[k]) begin
				rest -= NumeralWeight[k];
				if (NumeralText[k][15:8] != 8'd0)
					q.push_back(NumeralText[k][15:8]);
				q.push_back(NumeralText[k][7:0]);
			end
		end
		return q;
	endfunction

	// Turn a numeral written out in the table into its letters.
	function automatic letter_q_t spelled(string s);
		letter_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(char_t'(s[i]));
		return q;
	endfunction

	// Queue the letters of one numeral, flagging the final one.
	function automatic void owe_numeral(letter_q_t q);
		foreach (q[i])
			letters_due.push_back('{code: q[i], last: (i == q.size() - 1)});
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= ReportLimit)
			$display("%0t: %s", $time, msg);
	endfunction

	// Random values: mostly full range, with zeros, short numerals, the high
	// end where the fourth M shows up, and single-bit-cleared patterns.
	function automatic value_t random_value();
		case ($urandom_range(9))
			0: return '0;
			1, 2: return value_t'($urandom_range(1, 39));
			3: return value_t'($urandom_range(3000, 4095));
			4: return ~(value_t'(1) << $urandom_range(ValueWidth - 1));
			default: return value_t'($urandom_range(4095));
		endcase
	endfunction

	// Offer one value, holding it until the block takes the beat, then log
	// the letters it owes.
	task automatic offer_number(value_t v, string text);
		letter_q_t letters;
		while ($urandom_range(99) < send_idle_pct) begin
			number_ch.valid <= 1'b0;
			@(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		do
			@(posedge clk);
		while (!number_ch.ready);
		if (text == Predicted)
			letters = roman_letters(v);
		else
			letters = spelled(text);
		owe_numeral(letters);
	endtask

	// Compare one accepted letter with the oldest one owed.
	task automatic check_letter();
		letter_t want;
		if (letters_due.size() == 0) begin
			note_fault($sformatf("unexpected letter '%c' last=%0b",
				numeral_ch.char_code, numeral_ch.last));
		end else begin
			want = letters_due.pop_front();
			if (numeral_ch.char_code !== want.code || numeral_ch.last !== want.last)
				note_fault($sformatf("letter mismatch: want '%c' last=%0b, got '%c' (%02h) last=%0b",
					want.code, want.last, numeral_ch.char_code,
					numeral_ch.char_code, numeral_ch.last));
		end
	endtask

	// Receiver: sample the beat at the edge, then pick ready for the next cycle.
	initial begin
		numeral_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && numeral_ch.valid === 1'b1 && numeral_ch.ready)
				check_letter();
			numeral_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long hold-off: freeze the receiver for a fixed stretch while the sender
	// keeps pushing, so the front queue fills and number.ready drops.
	initial begin
		wait (squeeze_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (SqueezeCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Main sequence: reset, directed table, idling phases, pressure, drain.
	initial begin
		number_ch.valid <= 1'b0;
		number_ch.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with no idling on either side.
		for (int i = 0; i < DirectedRows; i++)
			offer_number(row_value[i], row_text[i]);

		// Random values across the idling phases.
		repeat (100) offer_number(random_value(), Predicted);

		send_idle_pct = 75;
		repeat (100) offer_number(random_value(), Predicted);

		send_idle_pct = 0;
		recv_stall_pct <= 75;
		repeat (100) offer_number(random_value(), Predicted);

		send_idle_pct = 37;
		recv_stall_pct <= 37;
		repeat (80) offer_number(random_value(), Predicted);

		// Back-pressure: receiver held off, sender offering back to back.
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		squeeze_go = 1'b1;
		repeat (40) offer_number(random_value(), Predicted);

		number_ch.valid <= 1'b0;

		// Drain every owed letter, then give stray letters time to show.
		wait (letters_due.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
